// ===== rtl/core/prma_pkg.sv =====
package prma_pkg;
	localparam int CHAN_W  = 16;
	localparam int CNT_W   = 16;
	localparam int IDX_W   = 16;
	localparam int COORD_W = 8;
	localparam int DIM_W   = 9;
	localparam int QUO_W   = CHAN_W + 1;
	localparam int SUM_W   = CHAN_W + 2;

	// Division of the channel sum by three: floor(sum * DIV3_RECIP / 2^DIV3_SHIFT)
	// is exact for every sum below 2^DIV3_SHIFT.
	localparam logic [SUM_W-1:0] DIV3_RECIP = 18'd174763;
	localparam int DIV3_SHIFT = 19;

	typedef enum logic [1:0] {
		REQ_ADD    = 2'd0,
		REQ_READ   = 2'd1,
		REQ_REGION = 2'd2,
		REQ_CLEAR  = 2'd3
	} req_t;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_IDX,
		ST_RD,
		ST_DIV,
		ST_WB,
		ST_SUM,
		ST_DIV3,
		ST_SCAN,
		ST_SCAN_END,
		ST_CLEAR,
		ST_OUT
	} state_t;

	localparam logic [2:0] REG_WIDTH  = 3'd0;
	localparam logic [2:0] REG_HEIGHT = 3'd4;
	localparam logic [DIM_W-1:0] DIM_LIMIT = 9'd256;
endpackage

// ===== rtl/core/pixel_running_mean_accumulator_top.sv =====
// An add runs a serial divider with the three channels in parallel; a region request
// scans every pixel of the rectangle; a clear zeroes the counts, one count per cycle.
// One request at a time; the next transfer is taken in the cycle after the result is
// registered, even while that result still waits for the receiver.
// Reset (arst_n, asynchronous) sets width and height to 256 and runs a pass that zeroes
// both memories; no transfer is taken until it ends.
module pixel_running_mean_accumulator_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_tvalid,
	output logic        s_tready,
	// tdata: x, y, x_end, y_end, red_in, green_in, blue_in (low to high)
	input  logic [79:0] s_tdata,
	// tuser: req_type
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// tdata: red_mean, green_mean, blue_mean, brightness, sample_count,
	// min_count, max_count, status, seven zero bits (low to high)
	output logic [119:0] m_tdata
);
	import prma_pkg::*;

	logic [DIM_W-1:0] width_q, height_q;
	logic [DIM_W-1:0] w_eff, h_eff;
	state_t state_q, state_d;

	// Memories: means and counts, registered read.
	logic [3*CHAN_W-1:0] mean_mem [0:(1<<IDX_W)-1];
	logic [CNT_W-1:0]    cnt_mem  [0:(1<<IDX_W)-1];
	logic [3*CHAN_W-1:0] mean_rd_q;
	logic [CNT_W-1:0]    cnt_rd_q;
	logic                mean_we, cnt_we;
	logic [IDX_W-1:0]    rd_addr, wr_addr;
	logic [3*CHAN_W-1:0] mean_wd;
	logic [CNT_W-1:0]    cnt_wd;

	// Request registers.
	req_t              req_q;
	logic [COORD_W-1:0] x_q, y_q, xe_q, ye_q, cx_q, cy_q;
	logic [CHAN_W-1:0] samp_q [3];
	logic [IDX_W-1:0]  idx_q, row_q;
	logic [IDX_W:0]    clr_q;
	logic [CNT_W-1:0]  cnt_q, mn_q, mx_q;
	logic [CHAN_W-1:0] mean_q [3];
	logic              first_q;

	// Serial divider: three lanes of |diff| / count.
	logic [CNT_W-1:0]  dvs_q;
	logic [QUO_W-1:0]  num_q [3];
	logic [CNT_W:0]    rem_q [3];
	logic [4:0]        step_q;
	logic [2:0]        neg_q;

	// Brightness: channel sum times the reciprocal of three.
	logic [SUM_W-1:0]   sum_q;
	logic [SUM_W-1:0]   mean_sum;
	logic [2*SUM_W-1:0] bright_prod;

	// The result is built in res_q and moved to the output register out_q.
	logic [119:0] res_q, out_d;
	logic [119:0] out_q;
	logic         out_v_q;
	logic         out_free;

	always_comb begin
		w_eff = (width_q == '0) ? 9'd1 : ((width_q > DIM_LIMIT) ? DIM_LIMIT : width_q);
		h_eff = (height_q == '0) ? 9'd1 : ((height_q > DIM_LIMIT) ? DIM_LIMIT : height_q);
	end

	assign pready = 1'b1;
	always_comb begin
		unique case (paddr)
			REG_WIDTH:  prdata = {23'd0, width_q};
			REG_HEIGHT: prdata = {23'd0, height_q};
			default:    prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_LIMIT;
			height_q <= DIM_LIMIT;
		end else if (psel && penable && pwrite) begin
			if (paddr == REG_WIDTH) width_q <= pwdata[DIM_W-1:0];
			if (paddr == REG_HEIGHT) height_q <= pwdata[DIM_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (mean_we) mean_mem[wr_addr] <= mean_wd;
		if (cnt_we) cnt_mem[wr_addr] <= cnt_wd;
		mean_rd_q <= mean_mem[rd_addr];
		cnt_rd_q  <= cnt_mem[rd_addr];
	end

	// A waiting result does not hold off the next request; only its final
	// move into the output register waits for the receiver.
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_v_q;
	assign m_tdata  = out_q;
	assign out_free = !out_v_q || m_tready;

	logic in_fire;
	assign in_fire = s_tvalid && s_tready;

	// Coordinate checks on the registered request; index fits since w,h <= 256.
	logic bad_a, bad_r;
	always_comb begin
		bad_a = ({1'b0, x_q} >= w_eff) || ({1'b0, y_q} >= h_eff);
		bad_r = bad_a || ({1'b0, xe_q} >= w_eff) || ({1'b0, ye_q} >= h_eff)
			|| (x_q > xe_q) || (y_q > ye_q);
	end

	// Pixel index, issued to the memories in ST_IDX so the data is there in ST_RD.
	logic [IDX_W-1:0] idx_calc;
	assign idx_calc = IDX_W'(y_q * w_eff + {1'b0, x_q});

	logic [IDX_W-1:0] cell_idx, next_cell_idx;
	assign cell_idx = row_q + IDX_W'(cx_q);
	assign next_cell_idx = (cx_q == xe_q) ? row_q + IDX_W'(w_eff) + IDX_W'(x_q)
		: cell_idx + IDX_W'(1);

	logic [CNT_W-1:0] cnt_new;
	assign cnt_new = (cnt_rd_q == '1) ? cnt_rd_q : cnt_rd_q + 1'b1;

	assign mean_sum = {2'b00, mean_q[0]} + {2'b00, mean_q[1]} + {2'b00, mean_q[2]};
	assign bright_prod = {SUM_W'(0), sum_q} * {SUM_W'(0), DIV3_RECIP};

	// Divider step per lane.
	logic [CNT_W:0]   rem_sh [3];
	logic [CNT_W:0]   rem_sub [3];
	logic             take [3];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rem_sh[i]  = {rem_q[i][CNT_W-1:0], num_q[i][QUO_W-1]};
			take[i]    = rem_sh[i] >= {1'b0, dvs_q};
			rem_sub[i] = take[i] ? rem_sh[i] - {1'b0, dvs_q} : rem_sh[i];
		end
	end

	logic [CHAN_W-1:0] new_mean [3];
	always_comb begin
		for (int i = 0; i < 3; i++)
			new_mean[i] = neg_q[i] ? mean_q[i] - num_q[i][CHAN_W-1:0]
				: mean_q[i] + num_q[i][CHAN_W-1:0];
	end

	// Region results take the scanned minimum and maximum.
	always_comb begin
		out_d = res_q;
		if (req_q == REQ_REGION && !res_q[112]) begin
			out_d[95:80]  = mn_q;
			out_d[111:96] = mx_q;
		end
	end

	always_comb begin
		state_d = state_q;
		rd_addr = idx_q;
		wr_addr = idx_q;
		mean_we = 1'b0;
		cnt_we  = 1'b0;
		mean_wd = {new_mean[2], new_mean[1], new_mean[0]};
		cnt_wd  = cnt_q;
		unique case (state_q)
			ST_INIT: begin
				wr_addr = clr_q[IDX_W-1:0];
				mean_we = 1'b1;
				cnt_we  = 1'b1;
				mean_wd = '0;
				cnt_wd  = '0;
				if (clr_q[IDX_W]) state_d = ST_IDLE;
			end
			ST_IDLE: if (in_fire) state_d = ST_IDX;
			ST_IDX: begin
				rd_addr = idx_calc;
				if (req_q == REQ_CLEAR) state_d = ST_CLEAR;
				else if (req_q == REQ_REGION) state_d = bad_r ? ST_OUT : ST_SCAN;
				else state_d = bad_a ? ST_OUT : ST_RD;
			end
			ST_RD: state_d = (req_q == REQ_ADD) ? ST_DIV : ST_SUM;
			ST_DIV: if (step_q == 5'd0) state_d = ST_WB;
			ST_WB: begin
				mean_we = 1'b1;
				cnt_we  = 1'b1;
				state_d = ST_SUM;
			end
			ST_SUM: state_d = ST_DIV3;
			ST_DIV3: state_d = ST_OUT;
			ST_SCAN: begin
				rd_addr = cell_idx;
				state_d = ST_SCAN_END;
			end
			ST_SCAN_END: begin
				rd_addr = next_cell_idx;
				if (cx_q == xe_q && cy_q == ye_q) state_d = ST_OUT;
			end
			ST_CLEAR: begin
				wr_addr = clr_q[IDX_W-1:0];
				cnt_we  = 1'b1;
				cnt_wd  = '0;
				if (clr_q[IDX_W]) state_d = ST_OUT;
			end
			ST_OUT: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			clr_q   <= '0;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_INIT || state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
			else clr_q <= '0;
			if (state_q == ST_OUT && out_free) out_v_q <= 1'b1;
			else if (m_tvalid && m_tready) out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free) out_q <= out_d;
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				req_q <= req_t'(s_tuser);
				x_q  <= s_tdata[7:0];
				y_q  <= s_tdata[15:8];
				xe_q <= s_tdata[23:16];
				ye_q <= s_tdata[31:24];
				samp_q[0] <= s_tdata[47:32];
				samp_q[1] <= s_tdata[63:48];
				samp_q[2] <= s_tdata[79:64];
				res_q <= '0;
			end
			ST_IDX: begin
				idx_q   <= idx_calc;
				row_q   <= IDX_W'(y_q * w_eff);
				cx_q    <= x_q;
				cy_q    <= y_q;
				first_q <= 1'b1;
				res_q[112] <= (req_q == REQ_REGION) ? bad_r
					: ((req_q == REQ_CLEAR) ? 1'b0 : bad_a);
			end
			ST_RD: begin
				cnt_q  <= (req_q == REQ_ADD) ? cnt_new : cnt_rd_q;
				dvs_q  <= cnt_new;
				step_q <= 5'(QUO_W);
				for (int i = 0; i < 3; i++) begin
					mean_q[i] <= mean_rd_q[i*CHAN_W +: CHAN_W];
					neg_q[i]  <= samp_q[i] < mean_rd_q[i*CHAN_W +: CHAN_W];
					num_q[i]  <= (samp_q[i] < mean_rd_q[i*CHAN_W +: CHAN_W])
						? {1'b0, mean_rd_q[i*CHAN_W +: CHAN_W] - samp_q[i]}
						: {1'b0, samp_q[i] - mean_rd_q[i*CHAN_W +: CHAN_W]};
					rem_q[i]  <= '0;
				end
			end
			ST_DIV: begin
				if (step_q != 5'd0) begin
					step_q <= step_q - 1'b1;
					for (int i = 0; i < 3; i++) begin
						rem_q[i] <= rem_sub[i];
						num_q[i] <= {num_q[i][QUO_W-2:0], take[i]};
					end
				end
			end
			ST_WB: begin
				for (int i = 0; i < 3; i++) mean_q[i] <= new_mean[i];
			end
			ST_SUM: begin
				res_q[79:0] <= {cnt_q, res_q[63:48], mean_q[2], mean_q[1], mean_q[0]};
				sum_q <= mean_sum;
			end
			ST_DIV3: res_q[63:48] <= bright_prod[DIV3_SHIFT +: CHAN_W];
			ST_SCAN: cx_q <= cx_q;
			ST_SCAN_END: begin
				if (first_q || cnt_rd_q < mn_q) mn_q <= cnt_rd_q;
				if (first_q || cnt_rd_q > mx_q) mx_q <= cnt_rd_q;
				first_q <= 1'b0;
				if (cx_q == xe_q) begin
					cx_q  <= x_q;
					cy_q  <= cy_q + 1'b1;
					row_q <= row_q + IDX_W'(w_eff);
				end else cx_q <= cx_q + 1'b1;
			end
			default: ;
		endcase
	end

	// Scan reads the cell issued in the previous cycle: the first compare
	// happens in the cycle after ST_SCAN, and each ST_SCAN_END issues the next.

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> (state_q == ST_IDLE)) else $error("accept while busy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> m_tvalid) else $error("result dropped");
	a_no_wr_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !(mean_we || cnt_we)) else $error("stray write");
endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

// Testbench for the pixel running-mean accumulator. Requests are fed over the
// slave stream, results drain over the master stream, and every result is
// compared in full with the prediction of a local model of the pixel store.
module tb_top;
	import prma_pkg::*;

	localparam int MAX_PIX = 65536;
	localparam longint CYCLE_LIMIT = 64'd3000000;

	// Result fields as they come back over the master stream.
	typedef struct packed {
		logic [15:0] red;
		logic [15:0] green;
		logic [15:0] blue;
		logic [15:0] bright;
		logic [15:0] count;
		logic [15:0] cmin;
		logic [15:0] cmax;
		logic        status;
	} pix_result_t;

	// One directed request; has_fixed marks rows whose answer is typed in.
	typedef struct {
		req_t        kind;
		logic [7:0]  x0, y0, x1, y1;
		logic [15:0] r, g, b;
		bit          has_fixed;
		pix_result_t fixed;
	} req_row_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0]   paddr = '0;
	logic [31:0]  pwdata = '0;
	logic [31:0]  prdata;
	logic         pready;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	// tdata: x, y, x_end, y_end, red_in, green_in, blue_in (low to high)
	logic [79:0]  s_tdata = '0;
	// tuser: req_type
	logic [1:0]   s_tuser = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	// tdata: red_mean, green_mean, blue_mean, brightness, sample_count,
	// min_count, max_count, status, zero padding (low to high)
	logic [119:0] m_tdata;

	pixel_running_mean_accumulator_top DUT (.*);

	always #6 clk = ~clk;

	// Model state: channel means, sample counts and the two size registers.
	logic [15:0] mean_mem [MAX_PIX][3];
	logic [15:0] count_mem [MAX_PIX];
	logic [8:0]  width_reg, height_reg;

	pix_result_t pending_results[$];
	int          error_count = 0;
	int          results_seen = 0;
	int          sent_count = 0;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	longint      cycle_count = 0;

	// Zero and values above 256 both clamp to the legal range.
	function automatic int unsigned clamp_dim(logic [8:0] v);
		if (v == 0)
			return 1;
		if (v > 256)
			return 256;
		return v;
	endfunction

	// Range check of one coordinate pair; returns whether it is in range and gives the linear pixel index in idx.
	function automatic bit pixel_index(int unsigned x, int unsigned y, output int unsigned idx);
		int unsigned w, h;
		w = clamp_dim(width_reg);
		h = clamp_dim(height_reg);
		idx = y * w + x;
		return (x < w) && (y < h) && (idx < MAX_PIX);
	endfunction

	// Advances the model by one request and returns the result it expects.
	function automatic pix_result_t predict_pixel(req_row_t rq);
		pix_result_t res;
		int unsigned i0, i1, w, cnt, cx, cy, c;
		longint diff, samp;
		longint unsigned total;
		res = '0;
		if (rq.kind == REQ_CLEAR) begin
			foreach (count_mem[k]) count_mem[k] = '0;
			return res;
		end
		if (rq.kind == REQ_REGION) begin
			if (rq.x0 > rq.x1 || rq.y0 > rq.y1 || !pixel_index(rq.x0, rq.y0, i0) ||
					!pixel_index(rq.x1, rq.y1, i1)) begin
				res.status = 1'b1;
				return res;
			end
			w = clamp_dim(width_reg);
			res.cmin = count_mem[i0];
			res.cmax = count_mem[i0];
			for (cy = rq.y0; cy <= rq.y1; cy++)
				for (cx = rq.x0; cx <= rq.x1; cx++) begin
					if (count_mem[cy * w + cx] < res.cmin) res.cmin = count_mem[cy * w + cx];
					if (count_mem[cy * w + cx] > res.cmax) res.cmax = count_mem[cy * w + cx];
				end
			return res;
		end
		if (!pixel_index(rq.x0, rq.y0, i0)) begin
			res.status = 1'b1;
			return res;
		end
		if (rq.kind == REQ_ADD) begin
			cnt = count_mem[i0];
			if (cnt < 16'hFFFF) cnt++;
			count_mem[i0] = 16'(cnt);
			for (c = 0; c < 3; c++) begin
				samp = (c == 0) ? rq.r : (c == 1) ? rq.g : rq.b;
				diff = samp - longint'(mean_mem[i0][c]);
				// SystemVerilog division truncates toward zero like the spec asks.
				mean_mem[i0][c] = 16'(longint'(mean_mem[i0][c]) + diff / longint'(cnt));
			end
		end
		res.red = mean_mem[i0][0];
		res.green = mean_mem[i0][1];
		res.blue = mean_mem[i0][2];
		total = mean_mem[i0][0] + mean_mem[i0][1] + mean_mem[i0][2];
		res.bright = 16'(total / 3);
		res.count = count_mem[i0];
		return res;
	endfunction

	task automatic reg_write(logic [2:0] addr, logic [8:0] val);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= addr; pwdata <= {23'd0, val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		if (addr == REG_WIDTH)
			width_reg = val;
		else
			height_reg = val;
	endtask

	// Sends one request, optionally idling first, and queues its expectation.
	// tvalid stays high from one transfer into the next unless the sender idles.
	task automatic send_request(req_row_t rq);
		pix_result_t res;
		if ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct) @(posedge clk);
		end
		res = predict_pixel(rq);
		if (rq.has_fixed && res != rq.fixed) begin
			$display("%0t: model disagrees with fixed row: expected %h got %h",
				$time, rq.fixed, res);
			error_count++;
		end
		pending_results.push_back(res);
		s_tvalid <= 1'b1;
		s_tuser <= rq.kind;
		s_tdata <= {rq.b, rq.g, rq.r, rq.y1, rq.x1, rq.y0, rq.x0};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sent_count++;
	endtask

	// Waits until the block has answered everything it was given.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	function automatic req_row_t make_row(req_t k, int x0, int y0, int x1, int y1,
			int r, int g, int b);
		req_row_t rq;
		rq.kind = k;
		rq.x0 = 8'(x0); rq.y0 = 8'(y0); rq.x1 = 8'(x1); rq.y1 = 8'(y1);
		rq.r = 16'(r); rq.g = 16'(g); rq.b = 16'(b);
		rq.has_fixed = 0;
		rq.fixed = '0;
		return rq;
	endfunction

	// Random requests aimed mostly at a small corner so pixels accumulate
	// many samples, with some anywhere in the address space.
	function automatic req_row_t random_row();
		req_row_t rq;
		int unsigned pick, span;
		pick = $urandom_range(99);
		span = ($urandom_range(9) == 0) ? 255 : 5;
		rq = make_row(REQ_ADD, $urandom_range(span), $urandom_range(span), 0, 0,
			$urandom_range(16'hFFFF), $urandom_range(16'hFFFF), $urandom_range(16'hFFFF));
		if (pick < 55)
			rq.kind = REQ_ADD;
		else if (pick < 85)
			rq.kind = REQ_READ;
		else begin
			rq.kind = REQ_REGION;
			// Small rectangles keep the scan short; a few are malformed.
			rq.x1 = 8'(rq.x0 + $urandom_range(4) - (($urandom_range(15) == 0) ? 6 : 0));
			rq.y1 = 8'(rq.y0 + $urandom_range(4));
		end
		return rq;
	endfunction

	// Result checker and receiver stall generator.
	always @(posedge clk) begin
		pix_result_t got, want;
		if (m_tvalid && m_tready) begin
			got = '{m_tdata[15:0], m_tdata[31:16], m_tdata[47:32], m_tdata[63:48],
				m_tdata[79:64], m_tdata[95:80], m_tdata[111:96], m_tdata[112]};
			results_seen++;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				if (got !== want) begin
					$display("%0t: mismatch expected %h actual %h", $time, want, got);
					error_count++;
				end
			end
		end
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Watchdog over the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, pending_results.size());
			$display("** pixel_running_mean_accumulator_top: FAILED **");
			$finish;
		end
	end

	initial begin
		req_row_t dir[$];
		req_row_t rq;
		int phase, n;
		int idle_plan[4][2] = '{'{0, 0}, '{45, 0}, '{0, 45}, '{37, 37}};
		int dims[4][2] = '{'{256, 256}, '{17, 9}, '{0, 300}, '{1, 256}};

		foreach (mean_mem[k]) begin
			mean_mem[k][0] = '0; mean_mem[k][1] = '0; mean_mem[k][2] = '0;
			count_mem[k] = '0;
		end
		width_reg = 9'd256;
		height_reg = 9'd256;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part: fresh pixel read, first sample overwrite, extremes,
		// saturating channels, bad regions, and a clear.
		rq = make_row(REQ_READ, 0, 0, 0, 0, 0, 0, 0);
		rq.has_fixed = 1; dir.push_back(rq);
		rq = make_row(REQ_ADD, 0, 0, 0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		rq.has_fixed = 1;
		rq.fixed = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1, 16'd0, 16'd0, 1'b0};
		dir.push_back(rq);
		dir.push_back(make_row(REQ_ADD, 0, 0, 0, 0, 0, 0, 0));
		dir.push_back(make_row(REQ_ADD, 0, 0, 0, 0, 16'h1234, 16'h8000, 16'h0001));
		dir.push_back(make_row(REQ_ADD, 255, 255, 0, 0, 16'hAAAA, 16'h5555, 16'hFFFF));
		dir.push_back(make_row(REQ_ADD, 255, 255, 0, 0, 16'h5555, 16'hAAAA, 16'h0000));
		dir.push_back(make_row(REQ_READ, 255, 255, 0, 0, 0, 0, 0));
		dir.push_back(make_row(REQ_REGION, 0, 0, 2, 2, 0, 0, 0));
		dir.push_back(make_row(REQ_REGION, 254, 254, 255, 255, 0, 0, 0));
		rq = make_row(REQ_REGION, 3, 0, 2, 0, 0, 0, 0);
		rq.has_fixed = 1; rq.fixed = '0; rq.fixed.status = 1; dir.push_back(rq);
		rq = make_row(REQ_REGION, 0, 5, 0, 4, 0, 0, 0);
		rq.has_fixed = 1; rq.fixed = '0; rq.fixed.status = 1; dir.push_back(rq);
		rq = make_row(REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0);
		rq.has_fixed = 1; rq.fixed = '0; dir.push_back(rq);
		dir.push_back(make_row(REQ_READ, 0, 0, 0, 0, 0, 0, 0));
		dir.push_back(make_row(REQ_ADD, 0, 0, 0, 0, 16'h0F0F, 16'hF0F0, 16'h7FFF));
		foreach (dir[k]) send_request(dir[k]);
		drain();

		// Hammer one pixel so its count climbs.
		for (n = 0; n < 6; n++)
			send_request(make_row(REQ_ADD, 7, 3, 0, 0, 16'hFFFF - n, n, 16'h8000));
		drain();

		// Random phases, each under a different size setting and idle mix.
		for (phase = 0; phase < 4; phase++) begin
			reg_write(REG_WIDTH, 9'(dims[phase][0]));
			reg_write(REG_HEIGHT, 9'(dims[phase][1]));
			send_idle_pct = idle_plan[phase][0];
			recv_stall_pct = idle_plan[phase][1];
			if (phase == 2) begin
				// An out-of-range read and an in-range add on the last row of a narrow image.
				send_request(make_row(REQ_READ, 1, 0, 0, 0, 0, 0, 0));
				send_request(make_row(REQ_ADD, 0, 255, 0, 0, 1, 2, 3));
			end
			for (n = 0; n < 270; n++) begin
				// Stretches without idling fall inside every phase.
				if (n == 135) begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				if (n == 200) begin
					send_idle_pct = idle_plan[phase][0];
					recv_stall_pct = idle_plan[phase][1];
				end
				send_request(random_row());
			end
			drain();
		end
		// One clear near the end, then a whole-image region over a small image.
		send_request(make_row(REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0));
		send_request(make_row(REQ_REGION, 0, 0, 0, 255, 0, 0, 0));
		drain();

		$display("Sent %0d requests over four size settings and idle mixes, %0d results checked.",
			sent_count, results_seen);
		if (error_count == 0 && pending_results.size() == 0)
			$display("** pixel_running_mean_accumulator_top: PASSED **");
		else
			$display("** pixel_running_mean_accumulator_top: FAILED **");
		$finish;
	end
endmodule
